// ===== hw/rtl/sfp_pkg.sv =====
// Package with the constants, codes and types of the sync frame parser.
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

  localparam int MaxPayload = 8;
  localparam int LenW = $clog2(MaxPayload + 1);

  localparam logic [7:0] SyncFirst = 8'hAA;
  localparam logic [7:0] SyncSecond = 8'h55;
  localparam logic [7:0] CmdControl = 8'h01;
  localparam logic [8:0] MaxPayloadW = 9'(MaxPayload);
  localparam logic [LenW-1:0] ControlLen = LenW'(2);

  typedef enum logic [5:0] {
    PhHunt  = 6'b000001,
    PhSync2 = 6'b000010,
    PhCmd   = 6'b000100,
    PhLen   = 6'b001000,
    PhData  = 6'b010000,
    PhCsum  = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    StControl = 3'd0,
    StBadLen  = 3'd1,
    StUnknown = 3'd2,
    StCsErr   = 3'd3,
    StTooLong = 3'd4
  } status_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] node;
    logic [7:0] ctrl;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sync_frame_parser_with_checksum.sv =====
// Top level of the sync header frame parser with additive checksum.
// A result is registered when its checksum byte or an oversized length byte is accepted.
// Throughput: one byte per cycle while ready is high; a two-entry output register and skid stage decouple stalls.
// Input ready drops only while the skid stage is occupied.
// Reset is asynchronous and active low; the parser returns to hunting for the first sync byte.
// The payload bytes and result data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_parser_with_checksum (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic [2:0]      frame_status_o,
  output logic [7:0]      command_code_o,
  output logic [7:0]      payload_length_o,
  output logic [7:0]      target_node_o,
  output logic [7:0]      control_value_o
);

  sfp_pkg::phase_e phase_q, phase_d;
  logic [7:0] cmd_q, cmd_d;
  logic [sfp_pkg::LenW-1:0] len_q, len_d;
  logic [sfp_pkg::LenW-1:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] node_q, ctrl_q;
  logic       node_we, ctrl_we;
  logic [sfp_pkg::LenW:0] pos_inc;

  logic              res_vld;
  sfp_pkg::result_t  res;
  logic              in_fire, pop;

  logic              out_valid_q, skid_valid_q;
  sfp_pkg::result_t  out_q, skid_q;

  assign rx_ready_o = !skid_valid_q;
  assign in_fire = rx_valid_i && rx_ready_o;
  assign pos_inc = {1'b0, pos_q} + (sfp_pkg::LenW + 1)'(1);

  always_comb begin
    phase_d = phase_q;
    cmd_d = cmd_q;
    len_d = len_q;
    pos_d = pos_q;
    sum_d = sum_q;
    node_we = 1'b0;
    ctrl_we = 1'b0;
    res_vld = 1'b0;
    res.status = sfp_pkg::StUnknown;
    res.command = cmd_q;
    res.length = 8'(len_q);
    res.node = 8'h00;
    res.ctrl = 8'h00;
    case (phase_q)
      sfp_pkg::PhHunt: begin
        if (rx_byte_i == sfp_pkg::SyncFirst) begin
          phase_d = sfp_pkg::PhSync2;
        end
      end
      sfp_pkg::PhSync2: begin
        if (rx_byte_i == sfp_pkg::SyncSecond) begin
          phase_d = sfp_pkg::PhCmd;
        end else begin
          phase_d = sfp_pkg::PhHunt;
          cmd_d = 8'h00;
          len_d = '0;
          pos_d = '0;
          sum_d = 8'h00;
        end
      end
      sfp_pkg::PhCmd: begin
        cmd_d = rx_byte_i;
        sum_d = rx_byte_i;
        phase_d = sfp_pkg::PhLen;
      end
      sfp_pkg::PhLen: begin
        if ({1'b0, rx_byte_i} > sfp_pkg::MaxPayloadW) begin
          res_vld = 1'b1;
          res.status = sfp_pkg::StTooLong;
          res.length = rx_byte_i;
          phase_d = sfp_pkg::PhHunt;
          cmd_d = 8'h00;
          len_d = '0;
          pos_d = '0;
          sum_d = 8'h00;
        end else begin
          len_d = rx_byte_i[sfp_pkg::LenW-1:0];
          sum_d = sum_q + rx_byte_i;
          pos_d = '0;
          phase_d = (rx_byte_i == 8'h00) ? sfp_pkg::PhCsum : sfp_pkg::PhData;
        end
      end
      sfp_pkg::PhData: begin
        node_we = (pos_q == sfp_pkg::LenW'(0));
        ctrl_we = (pos_q == sfp_pkg::LenW'(1));
        pos_d = pos_inc[sfp_pkg::LenW-1:0];
        sum_d = sum_q + rx_byte_i;
        if (pos_inc >= {1'b0, len_q}) begin
          phase_d = sfp_pkg::PhCsum;
        end
      end
      sfp_pkg::PhCsum: begin
        res_vld = 1'b1;
        if (sum_q != rx_byte_i) begin
          res.status = sfp_pkg::StCsErr;
        end else if (cmd_q == sfp_pkg::CmdControl) begin
          if (len_q == sfp_pkg::ControlLen) begin
            res.status = sfp_pkg::StControl;
            res.node = node_q;
            res.ctrl = ctrl_q;
          end else begin
            res.status = sfp_pkg::StBadLen;
          end
        end else begin
          res.status = sfp_pkg::StUnknown;
        end
        phase_d = sfp_pkg::PhHunt;
        cmd_d = 8'h00;
        len_d = '0;
        pos_d = '0;
        sum_d = 8'h00;
      end
      default: begin
        phase_d = sfp_pkg::PhHunt;
        cmd_d = 8'h00;
        len_d = '0;
        pos_d = '0;
        sum_d = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfp_pkg::PhHunt;
      cmd_q <= 8'h00;
      len_q <= '0;
      pos_q <= '0;
      sum_q <= 8'h00;
    end else if (in_fire) begin
      phase_q <= phase_d;
      cmd_q <= cmd_d;
      len_q <= len_d;
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && node_we) begin
      node_q <= rx_byte_i;
    end
    if (in_fire && ctrl_we) begin
      ctrl_q <= rx_byte_i;
    end
  end

  assign pop = out_valid_q && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire && res_vld;
      end
    end else if (in_fire && res_vld) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire && res_vld) begin
      skid_q <= res;
    end
  end

  assign res_valid_o = out_valid_q;
  assign frame_status_o = out_q.status;
  assign command_code_o = out_q.command;
  assign payload_length_o = out_q.length;
  assign target_node_o = out_q.node;
  assign control_value_o = out_q.ctrl;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid stage holds a transaction while the output register is empty.");

  a_hunt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == sfp_pkg::PhHunt) |-> (sum_q == 8'h00 && pos_q == '0 && cmd_q == 8'h00))
    else $error("Frame state is not cleared while hunting.");

  a_control_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && frame_status_o == sfp_pkg::StControl) |->
    (command_code_o == sfp_pkg::CmdControl && payload_length_o == 8'd2))
    else $error("Control request reported for a frame that is not a control frame.");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && frame_status_o != sfp_pkg::StControl) |->
    (target_node_o == 8'h00 && control_value_o == 8'h00))
    else $error("Payload bytes reported on a status other than a control request.");

endmodule

`default_nettype wire
